// File: rtl/eas_pkg.sv
`default_nettype none
package eas_pkg;

	localparam int CORDIC_ITERATIONS = 24;
	localparam int CORDIC_TABLE_LEN = 31;
	localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > CORDIC_TABLE_LEN) ?
		CORDIC_TABLE_LEN : CORDIC_ITERATIONS;

	// Dividend width: 51-bit magnitude times 32-bit tick rate.
	localparam int DIV_NUM_W = 83;
	localparam int DIV_DEN_W = 36;
	localparam int DIV_Q_W = 33;

	localparam logic signed [31:0] PI_Q28 = 32'sd843314857;
	localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic signed [31:0] TWO_PI_Q28 = 32'sd1686629713;
	localparam logic [31:0] RPM_K_Q28 = 32'd2563369783;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	// 2^62 / TWO_PI_Q28, rounded down with margin so that a quotient estimate
	// built from it never exceeds the true quotient.
	localparam logic [31:0] TWO_PI_RECIP = 32'd2734261000;

	localparam logic [1:0] REG_RADIANS_PER_COUNT = 2'd0;
	localparam logic [1:0] REG_FILTER_COEFF = 2'd1;
	localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef struct packed {
		logic done;
		logic big;
		logic [DIV_Q_W-1:0] quot;
	} div_res_t;

	typedef struct packed {
		logic done;
		logic [31:0] sine;
		logic [31:0] cosine;
	} cor_res_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A8;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFC;
			5'd3: v = 32'h07F56EA6;
			5'd4: v = 32'h03FEAB76;
			5'd5: v = 32'h01FFD55B;
			5'd6: v = 32'h00FFFAAA;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEA;
			5'd9: v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/eas_mul.sv
`default_nettype none
module eas_mul (
	input wire logic clk,
	input wire logic signed [33:0] a,
	input wire logic signed [33:0] b,
	output logic signed [67:0] p
);

	logic signed [67:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule
`default_nettype wire

// File: rtl/eas_div.sv
`default_nettype none
module eas_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [eas_pkg::DIV_NUM_W-1:0] num,
	input wire logic [eas_pkg::DIV_DEN_W-1:0] den,
	output eas_pkg::div_res_t res
);

	localparam int CNT_W = $clog2(eas_pkg::DIV_NUM_W);

	logic [eas_pkg::DIV_NUM_W-1:0] num_q;
	logic [eas_pkg::DIV_DEN_W-1:0] den_q;
	logic [eas_pkg::DIV_DEN_W-1:0] rem_q;
	logic [eas_pkg::DIV_Q_W-1:0] quot_q;
	logic big_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [eas_pkg::DIV_DEN_W:0] trial;
	logic [eas_pkg::DIV_DEN_W:0] diff;
	logic ge;

	assign trial = {rem_q, num_q[eas_pkg::DIV_NUM_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(eas_pkg::DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits beyond the kept width only matter as an overflow mark.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[eas_pkg::DIV_NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[eas_pkg::DIV_DEN_W-1:0] : trial[eas_pkg::DIV_DEN_W-1:0];
			quot_q <= {quot_q[eas_pkg::DIV_Q_W-2:0], ge};
			big_q <= big_q | quot_q[eas_pkg::DIV_Q_W-1];
		end
	end

	assign res.done = done_q;
	assign res.big = big_q;
	assign res.quot = quot_q;

endmodule
`default_nettype wire

// File: rtl/eas_cordic.sv
`default_nettype none
module eas_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [31:0] angle,
	output eas_pkg::cor_res_t res
);

	logic signed [33:0] x_q, y_q;
	logic signed [34:0] z_q;
	logic flip_q;
	logic [4:0] i_q;
	logic busy_q;
	logic done_q;

	logic signed [32:0] ang_ext;
	logic signed [32:0] ang_fold;
	logic fold;
	logic signed [33:0] dx, dy;
	logic signed [34:0] at;
	logic signed [33:0] y_out, x_out;

	always_comb begin
		ang_ext = 33'(angle);
		fold = 1'b0;
		ang_fold = ang_ext;
		if (ang_ext > 33'(eas_pkg::HALF_PI_Q28)) begin
			ang_fold = ang_ext - 33'(eas_pkg::PI_Q28);
			fold = 1'b1;
		end else if (ang_ext < -33'(eas_pkg::HALF_PI_Q28)) begin
			ang_fold = ang_ext + 33'(eas_pkg::PI_Q28);
			fold = 1'b1;
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = 35'(signed'({1'b0, eas_pkg::atan_entry(i_q)}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(eas_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= eas_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= {ang_fold[32], ang_fold, 1'b0} <<< 1;
			flip_q <= fold;
		end else if (busy_q) begin
			if (!z_q[34]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign y_out = flip_q ? -y_q : y_q;
	assign x_out = flip_q ? -x_q : x_q;
	assign res.done = done_q;
	assign res.sine = y_out[31:0];
	assign res.cosine = x_out[31:0];

endmodule
`default_nettype wire

// File: rtl/encoder_angle_speed_estimator.sv
// A sample transaction runs the sequencer through the 83-step serial speed divider
// (skipped when elapsed_ticks is zero) and the 24 CORDIC iterations, with a reduction
// of the angle sum added when it leaves -pi..pi. s_tready is high only in idle, so a
// new sample is not taken before the last result is in the output register. A result
// held by m_tready stalls the sequencer. Reset: arst_n clears the sequencer, the
// accumulators and the output valid; the registers return to their default values.
`default_nettype none
module encoder_angle_speed_estimator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// encoder_count [31:0], elapsed_ticks [55:32]
	input wire logic [55:0] s_tdata,
	// command [0]
	input wire logic [0:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// wrapped_angle [31:0], sine_angle [63:32], cosine_angle [95:64],
	// speed_rad_s [127:96], filtered_rpm [159:128], unwrapped_angle [207:160],
	// raw_count [239:208]
	output logic [239:0] m_tdata,
	// speed_saturated [0]
	output logic [0:0] m_tuser,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MSTEP, ST_ACC, ST_MAG, ST_RQ, ST_RE, ST_RS, ST_RC, ST_MLO, ST_MHI,
		ST_NUM, ST_DIV, ST_F1, ST_F2, ST_F3, ST_R1, ST_R2, ST_COR, ST_OUT
	} state_t;

	state_t state_q;

	logic [19:0] rpc_q;
	logic [15:0] coef_q;
	logic [31:0] tps_q;

	logic signed [31:0] prev_q, angle_q, filt_q, count_q, speed_q, rpm_q;
	logic signed [47:0] uw_q;
	logic [23:0] elapsed_q;
	logic signed [51:0] step_q;
	logic signed [52:0] asum_q;
	logic [51:0] aabs_q;
	logic [32:0] red_q;
	logic [50:0] mag_q;
	logic [63:0] plo_q;
	logic signed [49:0] p1_q;
	logic sat_q;

	logic out_valid_q;
	logic [239:0] out_data_q;
	logic out_sat_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	logic div_start;
	logic [eas_pkg::DIV_NUM_W-1:0] div_num;
	logic [eas_pkg::DIV_DEN_W-1:0] div_den;
	eas_pkg::div_res_t div_res;
	logic cor_start;
	eas_pkg::cor_res_t cor_res;

	logic s_fire;
	logic signed [31:0] delta;
	logic signed [52:0] usum;
	logic signed [47:0] uw_next;
	logic asum_in_range;
	logic signed [52:0] asum_abs;
	logic [52:0] red_full;
	logic red_big;
	logic signed [32:0] wr0, wr1, wr2;
	logic [16:0] one_minus;
	logic signed [50:0] fsum;
	logic signed [67:0] rsum;
	logic signed [39:0] rsh;
	logic signed [31:0] rpm_next;
	logic [32:0] q;
	logic step_neg, step_zero;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire = s_tvalid && s_tready;

	eas_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	eas_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .res(div_res)
	);

	eas_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(angle_q), .res(cor_res)
	);

	assign delta = prev_q - count_q;
	assign step_neg = step_q[51];
	assign step_zero = (step_q == '0);
	assign q = div_res.quot;

	// The step product is still on the multiplier output while the sums are formed.
	always_comb begin
		usum = 53'(uw_q) + 53'(signed'(mul_p[51:0]));
		if (usum[52:47] == {6{usum[52]}}) begin
			uw_next = usum[47:0];
		end else begin
			uw_next = usum[52] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		asum_in_range = (asum_q <= 53'(eas_pkg::PI_Q28)) &&
			(asum_q >= -53'(eas_pkg::PI_Q28));
		asum_abs = asum_q[52] ? -asum_q : asum_q;
	end

	// Reduction of the angle sum: a reciprocal estimate of the quotient by 2*pi falls
	// short by at most two, so the remainder is corrected by repeated subtraction.
	assign red_full = {1'b0, aabs_q} - mul_p[52:0];
	assign red_big = (red_q >= 33'(eas_pkg::TWO_PI_Q28));

	// The remainder takes the sign of the sum, then is brought into (-pi, pi].
	always_comb begin
		wr0 = asum_q[52] ? -33'(signed'({2'b0, red_q[30:0]})) :
			33'(signed'({2'b0, red_q[30:0]}));
		wr1 = (wr0 < 0) ? wr0 + 33'(eas_pkg::TWO_PI_Q28) : wr0;
		wr2 = (wr1 > 33'(eas_pkg::PI_Q28)) ? wr1 - 33'(eas_pkg::TWO_PI_Q28) : wr1;
	end

	always_comb begin
		one_minus = 17'h10000 - {1'b0, coef_q};
		fsum = 51'(p1_q) + 51'(signed'(mul_p[49:0])) + 51'sd32768;
		rsum = mul_p + 68'sd134217728;
		rsh = rsum[67:28];
		if (rsh[39:31] == {9{rsh[39]}}) begin
			rpm_next = rsh[31:0];
		end else begin
			rpm_next = rsh[39] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MSTEP: begin
				mul_a = 34'(delta);
				mul_b = {14'b0, rpc_q};
			end
			ST_RQ: begin
				mul_a = {2'b0, aabs_q[51:20]};
				mul_b = {2'b0, eas_pkg::TWO_PI_RECIP};
			end
			ST_RE: begin
				mul_a = {12'b0, mul_p[63:42]};
				mul_b = {2'b0, eas_pkg::TWO_PI_Q28};
			end
			ST_MLO: begin
				mul_a = {2'b0, mag_q[31:0]};
				mul_b = {2'b0, tps_q};
			end
			ST_MHI: begin
				mul_a = {15'b0, mag_q[50:32]};
				mul_b = {2'b0, tps_q};
			end
			ST_F1: begin
				mul_a = {17'b0, one_minus};
				mul_b = 34'(speed_q);
			end
			ST_F2: begin
				mul_a = {18'b0, coef_q};
				mul_b = 34'(filt_q);
			end
			ST_R1: begin
				mul_a = 34'(filt_q);
				mul_b = {2'b0, eas_pkg::RPM_K_Q28};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_NUM) && (elapsed_q != '0);
	assign div_num = eas_pkg::DIV_NUM_W'(plo_q) + {mul_p[50:0], 32'b0};
	assign div_den = {elapsed_q, 12'b0};
	assign cor_start = (state_q == ST_R2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rpc_q <= 20'd12555;
			coef_q <= 16'd47868;
			tps_q <= 32'd1000000;
			prev_q <= '0;
			angle_q <= '0;
			uw_q <= '0;
			filt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					eas_pkg::REG_RADIANS_PER_COUNT: rpc_q <= cfg_wdata[19:0];
					eas_pkg::REG_FILTER_COEFF: coef_q <= cfg_wdata[15:0];
					eas_pkg::REG_TICKS_PER_SECOND: tps_q <= cfg_wdata;
					default: ;
				endcase
			end
			if ((state_q == ST_OUT) && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						if (s_tuser[0] == eas_pkg::CMD_START) begin
							prev_q <= s_tdata[31:0];
							angle_q <= '0;
							uw_q <= '0;
							filt_q <= '0;
						end else begin
							state_q <= ST_MSTEP;
						end
					end
				end
				ST_MSTEP: state_q <= ST_ACC;
				ST_ACC: begin
					prev_q <= count_q;
					uw_q <= uw_next;
					state_q <= ST_MAG;
				end
				ST_MAG: begin
					if (asum_in_range) begin
						angle_q <= asum_q[31:0];
						state_q <= ST_MLO;
					end else begin
						state_q <= ST_RQ;
					end
				end
				ST_RQ: state_q <= ST_RE;
				ST_RE: state_q <= ST_RS;
				ST_RS: state_q <= ST_RC;
				ST_RC: begin
					if (!red_big) begin
						angle_q <= wr2[31:0];
						state_q <= ST_MLO;
					end
				end
				ST_MLO: state_q <= ST_MHI;
				ST_MHI: state_q <= ST_NUM;
				ST_NUM: state_q <= (elapsed_q == '0) ? ST_F1 : ST_DIV;
				ST_DIV: if (div_res.done) state_q <= ST_F1;
				ST_F1: state_q <= ST_F2;
				ST_F2: state_q <= ST_F3;
				ST_F3: begin
					filt_q <= fsum[47:16];
					state_q <= ST_R1;
				end
				ST_R1: state_q <= ST_R2;
				ST_R2: state_q <= ST_COR;
				ST_COR: if (cor_res.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					count_q <= s_tdata[31:0];
					elapsed_q <= s_tdata[55:32];
				end
			end
			ST_ACC: begin
				step_q <= mul_p[51:0];
			end
			ST_MAG: begin
				mag_q <= step_neg ? 51'(-step_q) : step_q[50:0];
				aabs_q <= asum_abs[51:0];
			end
			ST_RS: begin
				red_q <= red_full[32:0];
			end
			ST_RC: begin
				if (red_big) begin
					red_q <= red_q - 33'(eas_pkg::TWO_PI_Q28);
				end
			end
			ST_MHI: begin
				plo_q <= mul_p[63:0];
			end
			ST_NUM: begin
				if (elapsed_q == '0) begin
					sat_q <= 1'b1;
					if (step_zero) begin
						speed_q <= '0;
					end else begin
						speed_q <= step_neg ? 32'sh80000000 : 32'sh7FFFFFFF;
					end
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					if (!step_neg) begin
						if (div_res.big || q[32] || q[31]) begin
							speed_q <= 32'sh7FFFFFFF;
							sat_q <= 1'b1;
						end else begin
							speed_q <= q[31:0];
							sat_q <= 1'b0;
						end
					end else begin
						if (div_res.big || q[32] || (q[31] && (q[30:0] != '0))) begin
							speed_q <= 32'sh80000000;
							sat_q <= 1'b1;
						end else begin
							speed_q <= -q[31:0];
							sat_q <= 1'b0;
						end
					end
				end
			end
			ST_F2: begin
				p1_q <= mul_p[49:0];
			end
			ST_R2: begin
				rpm_q <= rpm_next;
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {count_q, uw_q, rpm_q, speed_q,
						cor_res.cosine, cor_res.sine, angle_q};
					out_sat_q <= sat_q;
				end
			end
			default: ;
		endcase
		// The raw angle sum is registered in ST_ACC, while the step product is on the multiplier output.
		if (state_q == ST_ACC) begin
			asum_q <= 53'(angle_q) + 53'(signed'(mul_p[51:0]));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_sat_q;

`ifndef SYNTHESIS
	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == eas_pkg::CMD_SAMPLE) |=> state_q == ST_MSTEP)
		else $error("sample transaction did not start the sequence");
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside its waiting state");
	a_cordic_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cor_res.done |-> state_q == ST_COR)
		else $error("CORDIC finished outside its waiting state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COR) |-> !s_tready)
		else $error("input accepted while a sample is in progress");
`endif

endmodule
`default_nettype wire

// File: test/eas_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module eas_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [55:0] s_tdata,
	input wire logic [0:0] s_tuser,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [239:0] m_tdata,
	input wire logic [0:0] m_tuser,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_wdata,
	output int errors,
	output int pending
);

	typedef struct {
		logic [31:0] wrapped;
		logic [31:0] sine;
		logic [31:0] cosine;
		logic [31:0] speed;
		logic [31:0] rpm;
		logic [47:0] unwrapped;
		logic [31:0] raw;
		logic sat;
	} estimate_t;

	localparam longint UNW_MAX = 64'sd140737488355327;
	localparam longint ARC_TAB[31] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
		'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
		'h00000001
	};

	logic [19:0] rad_per_count;
	logic [15:0] pole;
	logic [31:0] tick_rate;
	logic [31:0] last_count;
	longint angle, unwrapped, lp_speed;
	estimate_t estimates[$];

	assign pending = estimates.size();

	function automatic void rotate(input longint ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit flip;
		x = eas_pkg::CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (ang > eas_pkg::HALF_PI_Q28) begin
			ang -= eas_pkg::PI_Q28;
			flip = 1;
		end else if (ang < -eas_pkg::HALF_PI_Q28) begin
			ang += eas_pkg::PI_Q28;
			flip = 1;
		end
		z = ang * 4;
		for (int i = 0; i < eas_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARC_TAB[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARC_TAB[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic void estimate_sample(input logic [31:0] cnt, input logic [23:0] elapsed);
		estimate_t e;
		longint delta, step, sum, mag, speed, rpm, s, c;
		logic [127:0] quot;
		e.sat = 0;
		delta = longint'($signed(last_count - cnt));
		step = delta * longint'({44'd0, rad_per_count});
		sum = unwrapped + step;
		if (sum > UNW_MAX) sum = UNW_MAX;
		if (sum < -UNW_MAX - 1) sum = -UNW_MAX - 1;
		unwrapped = sum;
		sum = angle + step;
		if (sum > eas_pkg::PI_Q28 || sum < -eas_pkg::PI_Q28) begin
			sum = sum % eas_pkg::TWO_PI_Q28;
			if (sum < 0) sum += eas_pkg::TWO_PI_Q28;
			if (sum > eas_pkg::PI_Q28) sum -= eas_pkg::TWO_PI_Q28;
		end
		angle = sum;
		mag = step < 0 ? -step : step;
		if (elapsed == 0) begin
			e.sat = 1;
			speed = step > 0 ? 64'sd2147483647 : (step < 0 ? -64'sd2147483648 : 0);
		end else begin
			quot = (128'(mag) * 128'(tick_rate)) / (128'(elapsed) << 12);
			if (step >= 0) begin
				if (quot > 128'h7FFFFFFF) begin
					quot = 128'h7FFFFFFF;
					e.sat = 1;
				end
				speed = longint'(quot[63:0]);
			end else begin
				if (quot > 128'h80000000) begin
					quot = 128'h80000000;
					e.sat = 1;
				end
				speed = -longint'(quot[63:0]);
			end
		end
		lp_speed = ((65536 - longint'(pole)) * speed + longint'(pole) * lp_speed + 32768) >>> 16;
		rpm = (lp_speed * longint'(eas_pkg::RPM_K_Q28) + (64'sd1 << 27)) >>> 28;
		if (rpm > 64'sd2147483647) rpm = 64'sd2147483647;
		if (rpm < -64'sd2147483648) rpm = -64'sd2147483648;
		rotate(angle, s, c);
		last_count = cnt;
		e.wrapped = angle[31:0];
		e.sine = s[31:0];
		e.cosine = c[31:0];
		e.speed = speed[31:0];
		e.rpm = rpm[31:0];
		e.unwrapped = unwrapped[47:0];
		e.raw = cnt;
		estimates.push_back(e);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_per_count = 20'd12555;
			pole = 16'd47868;
			tick_rate = 32'd1000000;
			last_count = '0;
			angle = 0;
			unwrapped = 0;
			lp_speed = 0;
			estimates.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					eas_pkg::REG_RADIANS_PER_COUNT: rad_per_count = cfg_wdata[19:0];
					eas_pkg::REG_FILTER_COEFF: pole = cfg_wdata[15:0];
					eas_pkg::REG_TICKS_PER_SECOND: tick_rate = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == eas_pkg::CMD_START) begin
					last_count = s_tdata[31:0];
					angle = 0;
					unwrapped = 0;
					lp_speed = 0;
				end else begin
					estimate_sample(s_tdata[31:0], s_tdata[55:32]);
				end
			end
			if (m_tvalid && m_tready) begin
				if (estimates.size() == 0) begin
					$error("result transaction with no sample outstanding");
					errors++;
				end else begin
					estimate_t e;
					e = estimates.pop_front();
					if (m_tdata[31:0] !== e.wrapped) begin
						$error("wrapped_angle: expected %0d, got %0d",
							$signed(e.wrapped), $signed(m_tdata[31:0]));
						errors++;
					end
					if (m_tdata[63:32] !== e.sine) begin
						$error("sine_angle: expected %0d, got %0d",
							$signed(e.sine), $signed(m_tdata[63:32]));
						errors++;
					end
					if (m_tdata[95:64] !== e.cosine) begin
						$error("cosine_angle: expected %0d, got %0d",
							$signed(e.cosine), $signed(m_tdata[95:64]));
						errors++;
					end
					if (m_tdata[127:96] !== e.speed) begin
						$error("speed_rad_s: expected %0d, got %0d",
							$signed(e.speed), $signed(m_tdata[127:96]));
						errors++;
					end
					if (m_tdata[159:128] !== e.rpm) begin
						$error("filtered_rpm: expected %0d, got %0d",
							$signed(e.rpm), $signed(m_tdata[159:128]));
						errors++;
					end
					if (m_tdata[207:160] !== e.unwrapped) begin
						$error("unwrapped_angle: expected %0d, got %0d",
							$signed(e.unwrapped), $signed(m_tdata[207:160]));
						errors++;
					end
					if (m_tdata[239:208] !== e.raw) begin
						$error("raw_count: expected %0d, got %0d",
							$signed(e.raw), $signed(m_tdata[239:208]));
						errors++;
					end
					if (m_tuser[0] !== e.sat) begin
						$error("speed_saturated: expected %0d, got %0d", e.sat, m_tuser[0]);
						errors++;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: test/tb_encoder_angle_speed_estimator.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_encoder_angle_speed_estimator;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [239:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	int errors, pending;
	int cycles = 0;
	bit steady = 0;
	logic [31:0] position = '0;

	always #5 clk = ~clk;

	encoder_angle_speed_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	eas_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** encoder_angle_speed_estimator: FAILED **");
			$finish;
		end
	end

	// The receiver holds off for a long stretch early on so the block backs up,
	// and later accepts every result for a while.
	always @(posedge clk) begin
		if (cycles >= 20000 && cycles < 23000)
			m_tready <= 0;
		else if (cycles >= 60000 && cycles < 90000)
			m_tready <= 1;
		else
			m_tready <= $urandom_range(99) >= 29;
	end

	task automatic send(input logic cmd, input logic [31:0] cnt, input logic [23:0] elapsed);
		while (!steady && $urandom_range(99) < 29) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {elapsed, cnt};
		position = cnt;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_elapsed();
		int r;
		r = $urandom_range(99);
		if (r < 4) return 24'd0;
		if (r < 7) return 24'hFFFFFF;
		if (r < 20) return 24'($urandom);
		if (r < 30) return 24'($urandom_range(1, 8));
		return 24'($urandom_range(1, 5000));
	endfunction

	task automatic random_items(input int count);
		int r;
		logic [31:0] next;
		for (int i = 0; i < count; i++) begin
			steady = (i >= count / 2 && i < count / 2 + 60);
			r = $urandom_range(99);
			if (r < 3) begin
				send(eas_pkg::CMD_START, $urandom, pick_elapsed());
			end else begin
				if (r < 60)
					next = position + 32'($signed($urandom_range(0, 4000)) - 2000);
				else if (r < 85)
					next = position + 32'($signed($urandom_range(0, 400000)) - 200000);
				else
					next = $urandom;
				send(eas_pkg::CMD_SAMPLE, next, pick_elapsed());
			end
		end
		steady = 0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Sample before any start, then the directed cases at reset settings.
		send(eas_pkg::CMD_SAMPLE, 32'd100, 24'd1000);
		send(eas_pkg::CMD_START, 32'd0, 24'd0);
		send(eas_pkg::CMD_SAMPLE, 32'd0, 24'd0);
		send(eas_pkg::CMD_SAMPLE, 32'd10, 24'd0);
		send(eas_pkg::CMD_SAMPLE, 32'd0, 24'd0);
		send(eas_pkg::CMD_SAMPLE, 32'h7FFFFFFF, 24'd1);
		send(eas_pkg::CMD_SAMPLE, 32'h80000000, 24'hFFFFFF);
		send(eas_pkg::CMD_SAMPLE, 32'h7FFFFFFF, 24'd1);
		send(eas_pkg::CMD_SAMPLE, 32'hFFFFFFFF, 24'd3);
		send(eas_pkg::CMD_START, 32'h80000000, 24'hFFFFFF);
		send(eas_pkg::CMD_SAMPLE, 32'h80001000, 24'd50);
		send(eas_pkg::CMD_SAMPLE, 32'h80000000, 24'd50);
		for (int i = 0; i < 8; i++)
			send(eas_pkg::CMD_SAMPLE, position - 32'd60000, 24'd20);
		drain();

		// Largest step and rate, no filtering.
		write_reg(eas_pkg::REG_RADIANS_PER_COUNT, 32'hFFFFF);
		write_reg(eas_pkg::REG_FILTER_COEFF, 32'd0);
		write_reg(eas_pkg::REG_TICKS_PER_SECOND, 32'hFFFFFFFF);
		send(eas_pkg::CMD_START, 32'd0, 24'd0);
		send(eas_pkg::CMD_SAMPLE, 32'h80000000, 24'd1);
		send(eas_pkg::CMD_SAMPLE, 32'h7FFFFFFF, 24'hFFFFFF);
		send(eas_pkg::CMD_SAMPLE, 32'h00000000, 24'd0);
		random_items(350);
		drain();

		// Smallest step and rate, heaviest filtering.
		write_reg(eas_pkg::REG_RADIANS_PER_COUNT, 32'd1);
		write_reg(eas_pkg::REG_FILTER_COEFF, 32'hFFFF);
		write_reg(eas_pkg::REG_TICKS_PER_SECOND, 32'd1);
		random_items(350);
		drain();

		write_reg(eas_pkg::REG_RADIANS_PER_COUNT, 32'd12555);
		write_reg(eas_pkg::REG_FILTER_COEFF, 32'd47868);
		write_reg(eas_pkg::REG_TICKS_PER_SECOND, 32'd1000000);
		random_items(400);
		drain();

		write_reg(eas_pkg::REG_RADIANS_PER_COUNT, 32'($urandom_range(1, 20'hFFFFF)));
		write_reg(eas_pkg::REG_FILTER_COEFF, 32'($urandom_range(0, 16'hFFFF)));
		write_reg(eas_pkg::REG_TICKS_PER_SECOND, $urandom_range(1, 32'hFFFFFFFF));
		random_items(380);
		drain();

		if (errors == 0)
			$display("** encoder_angle_speed_estimator: PASSED **");
		else
			$display("** encoder_angle_speed_estimator: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
